### hdl/ppg_pkg.sv
package ppg_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned COS_ENTRIES = 256;

  localparam int unsigned PHASE_W     = $clog2(COS_ENTRIES);
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned COS_W       = 16;
  localparam int unsigned STATE_DEPTH = 1;

  localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd32;

  localparam logic [PHASE_W-1:0] COL_STEP_A   = PHASE_W'(5);
  localparam logic [PHASE_W-1:0] COL_STEP_B   = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] ROW_STEP_A   = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] ROW_STEP_B   = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] FRAME_STEP_0 = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] FRAME_STEP_1 = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] FRAME_STEP_2 = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] FRAME_STEP_3 = PHASE_W'(4);

  localparam logic signed [COS_W-1:0] COS_OFFSET = 16'sd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } ppg_reg_t;

  typedef logic [PHASE_W-1:0] ppg_phase_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } ppg_dims_t;

  // Whole raster/phase context, kept as one word in the state RAM
  typedef struct packed {
    ppg_phase_t [3:0] frame_phase;
    ppg_phase_t       row_phase_a;
    ppg_phase_t       row_phase_b;
    ppg_phase_t       col_phase_a;
    ppg_phase_t       col_phase_b;
    logic [7:0]       column_count;
    logic [7:0]       row_count;
  } ppg_state_t;

  // One pixel on its way to the color stages
  typedef struct packed {
    logic [7:0]             x;
    logic [7:0]             y;
    logic                   frame_end;
    logic [3:0][COS_W-1:0]  cos_val;
  } ppg_pix_t;

  // round(15360*cos(k*pi/32)), k = 0..16
  function automatic logic [14:0] quarter_wave(input logic [4:0] q);
    logic [14:0] v;
    case (q)
      5'd0:    v = 15'd15360;
      5'd1:    v = 15'd15286;
      5'd2:    v = 15'd15065;
      5'd3:    v = 15'd14699;
      5'd4:    v = 15'd14191;
      5'd5:    v = 15'd13546;
      5'd6:    v = 15'd12771;
      5'd7:    v = 15'd11873;
      5'd8:    v = 15'd10861;
      5'd9:    v = 15'd9744;
      5'd10:   v = 15'd8534;
      5'd11:   v = 15'd7241;
      5'd12:   v = 15'd5878;
      5'd13:   v = 15'd4459;
      5'd14:   v = 15'd2997;
      5'd15:   v = 15'd1506;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // 60*cos(i*pi/32)+4 in Q.8, folded from the quarter wave
  function automatic logic [COS_W-1:0] cos_lookup(input ppg_phase_t idx);
    logic [5:0]              k;
    logic [4:0]              q;
    logic                    neg;
    logic signed [COS_W-1:0] mag_s;
    logic signed [COS_W-1:0] v;
    k = idx[5:0];
    if (k <= 6'd16) begin
      q   = k[4:0];
      neg = 1'b0;
    end else if (k <= 6'd32) begin
      q   = 5'(6'd32 - k);
      neg = 1'b1;
    end else if (k <= 6'd48) begin
      q   = 5'(k - 6'd32);
      neg = 1'b1;
    end else begin
      q   = 5'(7'd64 - {1'b0, k});
      neg = 1'b0;
    end
    mag_s = signed'({1'b0, quarter_wave(q)});
    v     = neg ? -mag_s : mag_s;
    return COS_W'(v + COS_OFFSET);
  endfunction

  // Zero acts as one, oversize acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/ppg_ram.sv
module ppg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ppg_raster_state.sv
module ppg_raster_state
  import ppg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      pixel_request,
  input  ppg_dims_t dims,
  output logic      pix_valid,
  input  logic      pix_ready,
  output ppg_pix_t  pix
);

  localparam int unsigned AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

  logic       rv;
  logic       rd_init;
  logic       fwd_hit;
  logic       state_written;
  logic       pv;
  logic       adv_r;
  logic       rd_en;
  logic       wr_en;
  logic       row_end;
  logic       frm_end;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  ppg_state_t ram_q;
  ppg_state_t fwd_data;
  ppg_state_t cur;
  ppg_state_t nxt;
  ppg_pix_t   pix_reg;
  ppg_pix_t   pix_next;

  assign adv_r     = !pv || pix_ready;
  assign in_ready  = !rv || adv_r;
  assign rd_en     = in_valid && in_ready && pixel_request;
  assign wr_en     = rv && adv_r;
  assign pix_valid = pv;
  assign pix       = pix_reg;

  ppg_ram #(
    .WIDTH ($bits(ppg_state_t)),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(0)),
    .wdata (nxt),
    .re    (rd_en),
    .raddr (AW'(0)),
    .rdata (ram_q)
  );

  // Forward the word written in the cycle of the read; never-written reads as zero
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (rd_init) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    w_eff   = clamp_dim(dims.width, MAX_WIDTH_D);
    h_eff   = clamp_dim(dims.height, MAX_HEIGHT_D);
    row_end = ({1'b0, cur.column_count} + 9'd1) >= w_eff;
    frm_end = row_end && (({1'b0, cur.row_count} + 9'd1) >= h_eff);

    nxt = cur;
    if (frm_end) begin
      nxt.frame_phase[0] = cur.frame_phase[0] + FRAME_STEP_0;
      nxt.frame_phase[1] = cur.frame_phase[1] + FRAME_STEP_1;
      nxt.frame_phase[2] = cur.frame_phase[2] + FRAME_STEP_2;
      nxt.frame_phase[3] = cur.frame_phase[3] + FRAME_STEP_3;
      nxt.column_count   = '0;
      nxt.row_count      = '0;
      nxt.row_phase_a    = cur.frame_phase[0] + FRAME_STEP_0;
      nxt.row_phase_b    = cur.frame_phase[1] + FRAME_STEP_1;
      nxt.col_phase_a    = cur.frame_phase[2] + FRAME_STEP_2;
      nxt.col_phase_b    = cur.frame_phase[3] + FRAME_STEP_3;
    end else if (row_end) begin
      nxt.column_count = '0;
      nxt.row_count    = cur.row_count + 8'd1;
      nxt.row_phase_a  = cur.row_phase_a + ROW_STEP_A;
      nxt.row_phase_b  = cur.row_phase_b + ROW_STEP_B;
      nxt.col_phase_a  = cur.frame_phase[2];
      nxt.col_phase_b  = cur.frame_phase[3];
    end else begin
      nxt.column_count = cur.column_count + 8'd1;
      nxt.col_phase_a  = cur.col_phase_a + COL_STEP_A;
      nxt.col_phase_b  = cur.col_phase_b + COL_STEP_B;
    end

    pix_next.x          = cur.column_count;
    pix_next.y          = cur.row_count;
    pix_next.frame_end  = frm_end;
    pix_next.cos_val[0] = cos_lookup(cur.row_phase_a);
    pix_next.cos_val[1] = cos_lookup(cur.row_phase_b);
    pix_next.cos_val[2] = cos_lookup(cur.col_phase_a);
    pix_next.cos_val[3] = cos_lookup(cur.col_phase_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv            <= 1'b0;
      pv            <= 1'b0;
      rd_init       <= 1'b0;
      fwd_hit       <= 1'b0;
      state_written <= 1'b0;
    end else begin
      if (rd_en) begin
        rv      <= 1'b1;
        fwd_hit <= wr_en;
        rd_init <= state_written;
      end else if (wr_en) begin
        rv <= 1'b0;
      end
      if (wr_en) begin
        state_written <= 1'b1;
      end
      if (adv_r) begin
        pv <= rv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= nxt;
      pix_reg  <= pix_next;
    end
  end

endmodule

### hdl/ppg_color.sv
module ppg_color
  import ppg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_ready,
  input  ppg_pix_t   pix,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] pixel_x,
  output logic [7:0] pixel_y,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       frame_end
);

  logic              cv;
  logic [7:0]        c_x;
  logic [7:0]        c_y;
  logic              c_fe;
  logic [7:0]        c_idx;
  logic              dv;
  logic              adv_c;
  logic              adv_d;
  logic signed [17:0] sum;
  logic signed [17:0] neg_sum;
  logic [7:0]        idx_next;
  logic [7:0]        j4;
  logic [7:0]        r_next;
  logic [7:0]        g_next;
  logic [7:0]        b_next;

  assign adv_d     = !dv || out_ready;
  assign adv_c     = !cv || adv_d;
  assign pix_ready = adv_c;
  assign out_valid = dv;

  // Sum the four table values, truncate toward zero, keep the low byte
  always_comb begin
    sum = 18'(signed'(pix.cos_val[0])) + 18'(signed'(pix.cos_val[1]))
        + 18'(signed'(pix.cos_val[2])) + 18'(signed'(pix.cos_val[3]));
    neg_sum = -sum;
    if (sum[17]) begin
      idx_next = 8'(8'd0 - neg_sum[15:8]);
    end else begin
      idx_next = sum[15:8];
    end
  end

  // Four-segment gradient
  always_comb begin
    j4 = {c_idx[5:0], 2'b00};
    case (c_idx[7:6])
      2'd0: begin
        r_next = 8'hFF;
        g_next = j4;
        b_next = ~j4;
      end
      2'd1: begin
        r_next = ~j4;
        g_next = 8'hFF;
        b_next = j4;
      end
      2'd2: begin
        r_next = 8'h00;
        g_next = ~j4;
        b_next = 8'hFF;
      end
      default: begin
        r_next = j4;
        g_next = 8'h00;
        b_next = 8'hFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
      dv <= 1'b0;
    end else begin
      if (adv_c) begin
        cv <= pix_valid;
      end
      if (adv_d) begin
        dv <= cv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && pix_valid) begin
      c_x   <= pix.x;
      c_y   <= pix.y;
      c_fe  <= pix.frame_end;
      c_idx <= idx_next;
    end
    if (adv_d && cv) begin
      pixel_x   <= c_x;
      pixel_y   <= c_y;
      frame_end <= c_fe;
      red       <= r_next;
      green     <= g_next;
      blue      <= b_next;
    end
  end

endmodule

### hdl/plasma_pixel_generator_top.sv
// Plasma pixel generator: one plasma-colored pixel per request, in raster order.
//
// Input channel (in_valid/in_ready, pixel_request): each transfer with
// pixel_request high yields exactly one pixel; a transfer with it low is
// consumed and yields nothing. Output channel (out_valid/out_ready) carries
// pixel_x, pixel_y, red, green, blue and frame_end (high on the frame's last
// pixel). Configuration: cfg_write with cfg_index selects frame_width (0) or
// frame_height (1), written from cfg_data at the clock edge; write only while
// no pixel is in flight.
//
// Throughput: one pixel per clock while out_ready stays high. The whole raster
// context lives in one word of a single-port-per-side state RAM; each pixel
// reads it, updates it and writes it back once the pixel register can take
// it, and a back-to-back read takes the just written word from a forwarding
// register. Path: state RAM read, pixel register, color stage, output register.
// Reset: position and phases return to zero, width 64, height 32, all stages
// empty; no clearing pass is needed. When the receiver stalls, the pipeline
// keeps filling its empty stages and then drops in_ready.
module plasma_pixel_generator_top
  import ppg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   pixel_request,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             pixel_x,
  output logic [7:0]             pixel_y,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic                   frame_end,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  ppg_dims_t dims;
  logic      pix_valid;
  logic      pix_ready;
  ppg_pix_t  pix;

  // Hold the panel dimensions; clamping happens where they are used
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.width  <= WIDTH_RESET;
      dims.height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (ppg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  dims.width  <= cfg_data;
        REG_FRAME_HEIGHT: dims.height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read-modify-write of the raster context, table lookups
  ppg_raster_state u_state (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel_request (pixel_request),
    .dims          (dims),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix           (pix)
  );

  // Sum, truncate and map onto the gradient; owns the output register
  ppg_color u_color (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .frame_end (frame_end)
  );

  // A frame's last pixel sits at the last column and last row
  a_frame_end_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |->
      ((({1'b0, pixel_x} + 9'd1) >= dims.width) || (pixel_x == 8'hFF)) &&
      ((({1'b0, pixel_y} + 9'd1) >= dims.height) || (pixel_y == 8'hFF)))
    else $error("frame_end off the last raster position");

  // An empty output register means every stage can advance
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
